// ===== rtl/dll_pkg.sv =====
// shared types and constants of the linked-list core
package dll_pkg;

  localparam int unsigned NODES  = 64;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ADDR_W = $clog2(NODES);
  localparam int unsigned IDX_W  = ADDR_W + 1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  // null index sits just past the pool
  localparam idx_t NIL = IDX_W'(NODES);

  typedef enum logic [3:0] {
    K_CLEAR, K_INS_HEAD, K_INS_TAIL, K_CUR_HEAD, K_CUR_TAIL,
    K_DEL_HEAD, K_DEL_TAIL, K_DEL_AFTER, K_DEL_BEFORE,
    K_INS_AFTER, K_INS_BEFORE, K_SET, K_NEXT, K_PREV, K_QUERY
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE, ST_NO_EFFECT, ST_FULL
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_DEC, S_WR0, S_WR1, S_WR2,
    S_VH, S_VT, S_VC, S_FIN
  } ctrl_state_e;

  typedef struct packed {
    val_t val;
    idx_t fwd;
    idx_t bwd;
  } entry_t;

  typedef struct packed {
    logic   we_val;
    logic   we_fwd;
    logic   we_bwd;
    addr_t  addr;
    entry_t data;
  } wr_t;

  typedef struct packed {
    status_e    status;
    logic       list_empty;
    logic       cursor_valid;
    val_t       head_value;
    val_t       tail_value;
    val_t       cursor_value;
    idx_t       length;
  } res_t;

endpackage

// ===== rtl/dll_mem.sv =====
// node store: value, forward and backward link memories, one read and one write port
module dll_mem import dll_pkg::*; (
  input  logic   clk_i,
  input  logic   rd_en_i,
  input  addr_t  rd_addr_i,
  output entry_t rd_data_o,
  input  wr_t    wr_i
);

  val_t   val_mem [NODES];
  idx_t   fwd_mem [NODES];
  idx_t   bwd_mem [NODES];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_val) val_mem[wr_i.addr] <= wr_i.data.val;
    if (wr_i.we_fwd) fwd_mem[wr_i.addr] <= wr_i.data.fwd;
    if (wr_i.we_bwd) bwd_mem[wr_i.addr] <= wr_i.data.bwd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.val <= val_mem[rd_addr_i];
      rd_q.fwd <= fwd_mem[rd_addr_i];
      rd_q.bwd <= bwd_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/dll_ctrl.sv =====
// operation sequencer: reads links, updates list registers, writes nodes back
module dll_ctrl import dll_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  kind_i,
  input  val_t        value_i,
  output logic        rd_en_o,
  output addr_t       rd_addr_o,
  input  entry_t      rd_data_i,
  output wr_t         wr_o,
  input  logic        out_free_i,
  output logic        done_o,
  output res_t        res_o
);

  ctrl_state_e state_q, state_d;
  kind_e       kind_q;
  val_t        value_q;
  idx_t        head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  idx_t        free_q, free_d, fresh_q, fresh_d, cnt_q, cnt_d;
  status_e     status_q, status_d;
  entry_t      r1_q;
  wr_t         slot_q [3];
  wr_t         slot_d [3];
  val_t        hv_q, tv_q;
  logic        have_free, alloc_ok;
  idx_t        alloc_n, node_n, node_b, rd_idx;

  function automatic wr_t mk_wr(idx_t a, logic wv, logic wf, logic wb,
                                val_t v, idx_t f, idx_t bk);
    wr_t w;
    w.we_val   = wv;
    w.we_fwd   = wf;
    w.we_bwd   = wb;
    w.addr     = a[ADDR_W-1:0];
    w.data.val = v;
    w.data.fwd = f;
    w.data.bwd = bk;
    return w;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_DEC;
      S_DEC:   state_d = S_WR0;
      S_WR0:   state_d = S_WR1;
      S_WR1:   state_d = S_WR2;
      S_WR2:   state_d = S_VH;
      S_VH:    state_d = S_VT;
      S_VT:    state_d = S_VC;
      S_VC:    state_d = S_FIN;
      S_FIN:   if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    rd_idx     = NIL;
    wr_o       = '0;
    done_o     = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_RD1: begin
        rd_en_o = 1'b1;
        unique case (kind_q)
          K_INS_HEAD, K_INS_TAIL, K_INS_AFTER, K_INS_BEFORE: rd_idx = free_q;
          K_DEL_HEAD:                                        rd_idx = head_q;
          K_DEL_TAIL:                                        rd_idx = tail_q;
          default:                                           rd_idx = cur_q;
        endcase
      end
      S_RD2: begin
        rd_en_o = 1'b1;
        unique case (kind_q)
          K_DEL_AFTER:  rd_idx = rd_data_i.fwd;
          K_DEL_BEFORE: rd_idx = rd_data_i.bwd;
          default:      rd_idx = cur_q;
        endcase
      end
      S_WR0: wr_o = slot_q[0];
      S_WR1: wr_o = slot_q[1];
      S_WR2: wr_o = slot_q[2];
      S_VH: begin
        rd_en_o = 1'b1;
        rd_idx  = head_q;
      end
      S_VT: begin
        rd_en_o = 1'b1;
        rd_idx  = tail_q;
      end
      S_VC: begin
        rd_en_o = 1'b1;
        rd_idx  = cur_q;
      end
      S_FIN: done_o = out_free_i;
      default: ;
    endcase
  end

  assign rd_addr_o = rd_idx[ADDR_W-1:0];

  // operation decode, valid in the decode state with both reads returned
  assign have_free = (free_q != NIL);
  assign alloc_ok  = have_free || (fresh_q < NIL);
  assign alloc_n   = have_free ? free_q : fresh_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    cnt_d    = cnt_q;
    status_d = ST_DONE;
    slot_d[0] = '0;
    slot_d[1] = '0;
    slot_d[2] = '0;
    node_n   = NIL;
    node_b   = NIL;
    unique case (kind_q)
      K_CLEAR: begin
        head_d  = NIL;
        tail_d  = NIL;
        cur_d   = NIL;
        free_d  = NIL;
        fresh_d = '0;
        cnt_d   = '0;
      end
      K_INS_HEAD, K_INS_TAIL: begin
        if (!alloc_ok) begin
          status_d = ST_FULL;
        end else begin
          node_n = alloc_n;
          if (have_free) free_d = r1_q.fwd;
          else fresh_d = fresh_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (kind_q == K_INS_HEAD) begin
            slot_d[0] = mk_wr(node_n, 1'b1, 1'b1, 1'b1, value_q, head_q, NIL);
            if (head_q != NIL) slot_d[1] = mk_wr(head_q, 1'b0, 1'b0, 1'b1, '0, NIL, node_n);
            else tail_d = node_n;
            head_d = node_n;
          end else begin
            slot_d[0] = mk_wr(node_n, 1'b1, 1'b1, 1'b1, value_q, NIL, tail_q);
            if (tail_q != NIL) slot_d[1] = mk_wr(tail_q, 1'b0, 1'b1, 1'b0, '0, node_n, NIL);
            else head_d = node_n;
            tail_d = node_n;
          end
        end
      end
      K_CUR_HEAD: cur_d = head_q;
      K_CUR_TAIL: cur_d = tail_q;
      K_DEL_HEAD, K_DEL_TAIL: begin
        node_n = (kind_q == K_DEL_HEAD) ? head_q : tail_q;
        if (node_n == NIL) begin
          status_d = ST_NO_EFFECT;
        end else begin
          if (cur_q == node_n) cur_d = NIL;
          if (head_q == tail_q) begin
            head_d = NIL;
            tail_d = NIL;
          end else if (kind_q == K_DEL_HEAD) begin
            head_d    = r1_q.fwd;
            slot_d[0] = mk_wr(r1_q.fwd, 1'b0, 1'b0, 1'b1, '0, NIL, NIL);
          end else begin
            tail_d    = r1_q.bwd;
            slot_d[0] = mk_wr(r1_q.bwd, 1'b0, 1'b1, 1'b0, '0, NIL, NIL);
          end
          slot_d[1] = mk_wr(node_n, 1'b0, 1'b1, 1'b0, '0, free_q, NIL);
          free_d    = node_n;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      K_DEL_AFTER, K_DEL_BEFORE: begin
        node_n = (kind_q == K_DEL_AFTER) ? r1_q.fwd : r1_q.bwd;
        node_b = (kind_q == K_DEL_AFTER) ? rd_data_i.fwd : rd_data_i.bwd;
        if (cur_q == NIL || node_n == NIL) begin
          status_d = ST_NO_EFFECT;
        end else begin
          if (kind_q == K_DEL_AFTER) begin
            slot_d[0] = mk_wr(cur_q, 1'b0, 1'b1, 1'b0, '0, node_b, NIL);
            if (node_n == tail_q) tail_d = cur_q;
            else if (node_b != NIL) slot_d[1] = mk_wr(node_b, 1'b0, 1'b0, 1'b1, '0, NIL, cur_q);
          end else begin
            slot_d[0] = mk_wr(cur_q, 1'b0, 1'b0, 1'b1, '0, NIL, node_b);
            if (node_n == head_q) head_d = cur_q;
            else if (node_b != NIL) slot_d[1] = mk_wr(node_b, 1'b0, 1'b1, 1'b0, '0, cur_q, NIL);
          end
          slot_d[2] = mk_wr(node_n, 1'b0, 1'b1, 1'b0, '0, free_q, NIL);
          free_d    = node_n;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      K_INS_AFTER, K_INS_BEFORE: begin
        if (cur_q == NIL) begin
          status_d = ST_NO_EFFECT;
        end else if (!alloc_ok) begin
          status_d = ST_FULL;
        end else begin
          node_n = alloc_n;
          if (have_free) free_d = r1_q.fwd;
          else fresh_d = fresh_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (kind_q == K_INS_AFTER) begin
            node_b    = rd_data_i.fwd;
            slot_d[0] = mk_wr(node_n, 1'b1, 1'b1, 1'b1, value_q, node_b, cur_q);
            slot_d[1] = mk_wr(cur_q, 1'b0, 1'b1, 1'b0, '0, node_n, NIL);
            if (cur_q == tail_q) tail_d = node_n;
            else if (node_b != NIL) slot_d[2] = mk_wr(node_b, 1'b0, 1'b0, 1'b1, '0, NIL, node_n);
          end else begin
            node_b    = rd_data_i.bwd;
            slot_d[0] = mk_wr(node_n, 1'b1, 1'b1, 1'b1, value_q, cur_q, node_b);
            slot_d[1] = mk_wr(cur_q, 1'b0, 1'b0, 1'b1, '0, NIL, node_n);
            if (cur_q == head_q) head_d = node_n;
            else if (node_b != NIL) slot_d[2] = mk_wr(node_b, 1'b0, 1'b1, 1'b0, '0, node_n, NIL);
          end
        end
      end
      K_SET: begin
        if (cur_q == NIL) status_d = ST_NO_EFFECT;
        else slot_d[0] = mk_wr(cur_q, 1'b1, 1'b0, 1'b0, value_q, NIL, NIL);
      end
      K_NEXT: begin
        if (cur_q == NIL) status_d = ST_NO_EFFECT;
        else cur_d = (cur_q == tail_q) ? NIL : r1_q.fwd;
      end
      K_PREV: begin
        if (cur_q == NIL) status_d = ST_NO_EFFECT;
        else cur_d = (cur_q == head_q) ? NIL : r1_q.bwd;
      end
      K_QUERY: ;
      default: status_d = ST_NO_EFFECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= NIL;
      tail_q   <= NIL;
      cur_q    <= NIL;
      free_q   <= NIL;
      fresh_q  <= '0;
      cnt_q    <= '0;
      status_q <= ST_DONE;
    end else begin
      state_q <= state_d;
      if (state_q == S_DEC) begin
        head_q   <= head_d;
        tail_q   <= tail_d;
        cur_q    <= cur_d;
        free_q   <= free_d;
        fresh_q  <= fresh_d;
        cnt_q    <= cnt_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q  <= kind_e'(kind_i);
      value_q <= value_i;
    end
    if (state_q == S_RD2) r1_q <= rd_data_i;
    if (state_q == S_DEC) begin
      slot_q[0] <= slot_d[0];
      slot_q[1] <= slot_d[1];
      slot_q[2] <= slot_d[2];
    end
    if (state_q == S_VT) hv_q <= rd_data_i.val;
    if (state_q == S_VC) tv_q <= rd_data_i.val;
  end

  // result, the cursor value is still on the read port
  always_comb begin
    res_o.status       = status_q;
    res_o.list_empty   = (head_q == NIL);
    res_o.cursor_valid = (cur_q != NIL);
    res_o.head_value   = (head_q == NIL) ? '0 : hv_q;
    res_o.tail_value   = (tail_q == NIL) ? '0 : tv_q;
    res_o.cursor_value = (cur_q == NIL) ? '0 : rd_data_i.val;
    res_o.length       = cnt_q;
  end

endmodule

// ===== rtl/doubly_linked_list_with_cursor_core.sv =====
// top level of the doubly linked list core with cursor
//
// usage: one operation per input transfer (kind_i, value_i) on a valid/ready
// channel; each operation produces exactly one result transfer carrying the
// status, the empty and cursor flags, the head, tail and cursor values and
// the list length. values of absent nodes read as zero.
// one operation is in flight at a time: two link reads, three node write
// slots and three value reads, all sequenced over the single read and
// single write port of the node memory.
// the result sits in an output register; the next input transfer is taken
// while it waits, and a stalled receiver only holds the sequencer in its
// final step until the register frees up.
// reset: asynchronous, active low. the list, cursor and free list come up
// empty with every node fresh; the node memory is not cleared, as no data
// read from an entry before it has been written reaches a result.
module doubly_linked_list_with_cursor_core import dll_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              kind_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic                    list_empty_o,
  output logic                    cursor_valid_o,
  output logic signed [VAL_W-1:0] head_value_o,
  output logic signed [VAL_W-1:0] tail_value_o,
  output logic signed [VAL_W-1:0] cursor_value_o,
  output logic [IDX_W-1:0]        length_o
);

  logic   rd_en;
  addr_t  rd_addr;
  entry_t rd_data;
  wr_t    wr;
  logic   out_free, done;
  res_t   res, res_q;
  logic   out_valid_q;

  // node storage
  dll_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // operation sequencer
  dll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_o       (wr),
    .out_free_i (out_free),
    .done_o     (done),
    .res_o      (res)
  );

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (done) res_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign list_empty_o   = res_q.list_empty;
  assign cursor_valid_o = res_q.cursor_valid;
  assign head_value_o   = res_q.head_value;
  assign tail_value_o   = res_q.tail_value;
  assign cursor_value_o = res_q.cursor_value;
  assign length_o       = res_q.length;

endmodule

// ===== rtl/dll_checker.sv =====
// port-level checks of the linked-list core and their binding
module dll_checker import dll_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic [3:0]              kind_i,
  input logic signed [VAL_W-1:0] value_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [1:0]              status_o,
  input logic                    list_empty_o,
  input logic                    cursor_valid_o,
  input logic signed [VAL_W-1:0] head_value_o,
  input logic signed [VAL_W-1:0] tail_value_o,
  input logic signed [VAL_W-1:0] cursor_value_o,
  input logic [IDX_W-1:0]        length_o
);

  // a stalled result keeps its length, status, head value and cursor value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(length_o) && $stable(status_o)
      && $stable(head_value_o) && $stable(cursor_value_o))
    else $error("result changed while stalled");

  // empty flag agrees with the length
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (list_empty_o == (length_o == '0)))
    else $error("empty flag and length disagree");

  // an empty list has no cursor and zero head and tail values
  a_empty_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |-> !cursor_valid_o && head_value_o == '0
      && tail_value_o == '0)
    else $error("empty list reports a node");

  // no cursor reads as zero
  a_cursor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cursor_valid_o |-> cursor_value_o == '0)
    else $error("cursor value without a cursor");

endmodule

bind doubly_linked_list_with_cursor_core dll_checker u_dll_checker (.*);
